// File: hw/rtl/nsq_pkg.sv
// Shared types, constants and helper functions of the nine-slice quad generator.
// Used by the controller, the datapath, the top level and the port checker.
`timescale 1ns / 1ps

package nsq_pkg;

  // Field widths.
  localparam int POS_W      = 24;
  localparam int SIZE_W     = 23;
  localparam int UV_W       = 16;
  localparam int TEX_W      = 16;
  localparam int COLOR_W    = 32;
  localparam int VTX_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int FLAG_W     = 4;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 136;
  localparam int OUT_NUM_LSB = 128;

  // Working widths for edge arithmetic before saturation.
  localparam int EDGE_W  = 26;
  localparam int UVSUM_W = 19;
  localparam int PROD_W  = 24;

  // Image modes.
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_QUAD = 2'd1;
  localparam logic [1:0] MODE_NINE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UV_RECT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UV_MARGINS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_RATIOS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_RATIO    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_SIZE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_SLOT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR   = 3'd7;

  // Update flag positions in in_tuser.
  localparam int FLAG_TRANSFORM = 0;
  localparam int FLAG_SPRITE    = 1;
  localparam int FLAG_BORDER    = 2;
  localparam int FLAG_COLOR     = 3;

  localparam logic [VTX_W-1:0] MUL_LAST = 6'd3;
  localparam logic [VTX_W-1:0] QUAD_LAST = 6'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_EDGE,
    ST_WRITE,
    ST_EMIT
  } nsq_state_t;

  typedef struct packed {
    logic             capture;
    logic             mul_en;
    logic [1:0]       mul_sel;
    logic             edge_en;
    logic             wr_en;
    logic             rd_en;
    logic             rd_last;
    logic [VTX_W-1:0] addr;
  } nsq_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       rd_free;
    logic       run_done;
  } nsq_sts_t;

  // Saturate a wide signed edge to the signed position range.
  function automatic logic [POS_W-1:0] sat_pos(input logic signed [EDGE_W-1:0] v);
    logic [POS_W-1:0] res;
    if (v > $signed(EDGE_W'(24'sh7FFFFF))) begin
      res = 24'h7FFFFF;
    end else if (v < -$signed(EDGE_W'(26'sh0800000))) begin
      res = 24'h800000;
    end else begin
      res = v[POS_W-1:0];
    end
    return res;
  endfunction

  // Saturate a signed texture coordinate sum to unorm16.
  function automatic logic [UV_W-1:0] sat_uv(input logic signed [UVSUM_W-1:0] v);
    logic [UV_W-1:0] res;
    if (v[UVSUM_W-1]) begin
      res = '0;
    end else if (v[UVSUM_W-2:UV_W] != '0) begin
      res = 16'hFFFF;
    end else begin
      res = v[UV_W-1:0];
    end
    return res;
  endfunction

  // Edge indexes of a vertex: quads run column-major, three rows per column,
  // and the corners of a quad go (0,0) (0,1) (1,1) (1,0).
  // Returns {x edge, y edge}.
  function automatic logic [3:0] corner_edges(input logic [VTX_W-1:0] vtx);
    logic [3:0] quad;
    logic [1:0] col;
    logic [1:0] row;
    quad = vtx[5:2];
    if (quad < 4'd3) begin
      col = 2'd0;
      row = quad[1:0];
    end else if (quad < 4'd6) begin
      col = 2'd1;
      row = 2'(quad - 4'd3);
    end else begin
      col = 2'd2;
      row = 2'(quad - 4'd6);
    end
    return {2'(col + {1'b0, vtx[1]}), 2'(row + {1'b0, vtx[1] ^ vtx[0]})};
  endfunction

endpackage

// File: hw/rtl/nsq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 36,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/nsq_ctrl.sv
// Controller of the nine-slice quad generator: sequences multiply, edge,
// store-write and emit phases. Depends on nsq_pkg.
`timescale 1ns / 1ps

module nsq_ctrl #(
  parameter int MAX_VERTICES = 36
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  nsq_pkg::nsq_sts_t sts,
  output nsq_pkg::nsq_cmd_t cmd
);

  localparam logic [nsq_pkg::VTX_W-1:0] NINE_LAST = nsq_pkg::VTX_W'(MAX_VERTICES - 1);

  nsq_pkg::nsq_state_t state_r, state_nxt;
  logic [nsq_pkg::VTX_W-1:0] cnt_r, cnt_nxt;
  logic issued_r, issued_nxt;
  logic [nsq_pkg::VTX_W-1:0] last_idx;
  logic rd_issue;
  logic mode_on;

  assign last_idx = (sts.mode == nsq_pkg::MODE_QUAD) ? nsq_pkg::QUAD_LAST : NINE_LAST;
  assign mode_on  = (sts.mode == nsq_pkg::MODE_QUAD) || (sts.mode == nsq_pkg::MODE_NINE);
  // A store read goes out whenever the read-data slot will be free next cycle.
  assign rd_issue = (state_r == nsq_pkg::ST_EMIT) && sts.rd_free && !issued_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= nsq_pkg::ST_IDLE;
      cnt_r    <= '0;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      issued_r <= issued_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    issued_nxt = issued_r;
    unique case (state_r)
      nsq_pkg::ST_IDLE: begin
        cnt_nxt    = '0;
        issued_nxt = 1'b0;
        if (in_tvalid && mode_on) begin
          state_nxt = nsq_pkg::ST_MUL;
        end
      end
      nsq_pkg::ST_MUL: begin
        if (cnt_r == nsq_pkg::MUL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = nsq_pkg::ST_EDGE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      nsq_pkg::ST_EDGE: begin
        state_nxt = nsq_pkg::ST_WRITE;
      end
      nsq_pkg::ST_WRITE: begin
        if (cnt_r == last_idx) begin
          cnt_nxt   = '0;
          state_nxt = nsq_pkg::ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      nsq_pkg::ST_EMIT: begin
        if (rd_issue) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == last_idx) begin
            issued_nxt = 1'b1;
          end
        end
        if (sts.run_done) begin
          state_nxt = nsq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nsq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd         = '0;
    cmd.addr    = cnt_r;
    cmd.mul_sel = cnt_r[1:0];
    cmd.rd_last = (cnt_r == last_idx);
    unique case (state_r)
      nsq_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      nsq_pkg::ST_MUL:   cmd.mul_en  = 1'b1;
      nsq_pkg::ST_EDGE:  cmd.edge_en = 1'b1;
      nsq_pkg::ST_WRITE: cmd.wr_en   = 1'b1;
      nsq_pkg::ST_EMIT:  cmd.rd_en   = rd_issue;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/nsq_datapath.sv
// Datapath of the nine-slice quad generator: configuration registers, shared
// multiplier, edge registers, vertex stores and output register.
// Depends on nsq_pkg and nsq_ram.
`timescale 1ns / 1ps

module nsq_datapath #(
  parameter int MAX_VERTICES = 36
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [nsq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nsq_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic [nsq_pkg::IN_DATA_W-1:0]        in_tdata,
  input  logic [nsq_pkg::FLAG_W-1:0]           in_tuser,
  input  nsq_pkg::nsq_cmd_t                    cmd,
  output nsq_pkg::nsq_sts_t                    sts,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [nsq_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                 out_tlast
);

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int POS2  = 2 * nsq_pkg::POS_W;
  localparam int UVT_W = 2 * nsq_pkg::UV_W + nsq_pkg::TEX_W;

  // Configuration registers.
  logic [1:0]  mode_r;
  logic [63:0] uv_rect_r;
  logic [63:0] uv_marg_r;
  logic [63:0] edge_rat_r;
  logic [33:0] fit_r;
  logic [nsq_pkg::SIZE_W-1:0]  border_r;
  logic [nsq_pkg::TEX_W-1:0]   tex_slot_r;
  logic [nsq_pkg::COLOR_W-1:0] fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= nsq_pkg::MODE_OFF;
      uv_rect_r  <= '0;
      uv_marg_r  <= '0;
      edge_rat_r <= '0;
      fit_r      <= '0;
      border_r   <= '0;
      tex_slot_r <= '0;
      fill_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nsq_pkg::REG_IMAGE_MODE:   mode_r     <= cfg_wdata[1:0];
        nsq_pkg::REG_UV_RECT:      uv_rect_r  <= cfg_wdata;
        nsq_pkg::REG_UV_MARGINS:   uv_marg_r  <= cfg_wdata;
        nsq_pkg::REG_EDGE_RATIOS:  edge_rat_r <= cfg_wdata;
        nsq_pkg::REG_FIT_RATIO:    fit_r      <= cfg_wdata[33:0];
        nsq_pkg::REG_BORDER_SIZE:  border_r   <= cfg_wdata[nsq_pkg::SIZE_W-1:0];
        nsq_pkg::REG_TEXTURE_SLOT: tex_slot_r <= cfg_wdata[nsq_pkg::TEX_W-1:0];
        nsq_pkg::REG_FILL_COLOR:   fill_r     <= cfg_wdata[nsq_pkg::COLOR_W-1:0];
        default: begin
          mode_r <= mode_r;
        end
      endcase
    end
  end

  // Request capture.
  logic [nsq_pkg::POS_W-1:0]  cx_r, cy_r;
  logic [nsq_pkg::SIZE_W-1:0] w_r, h_r;
  logic [nsq_pkg::FLAG_W-1:0] flags_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cx_r    <= in_tdata[23:0];
      cy_r    <= in_tdata[47:24];
      w_r     <= in_tdata[70:48];
      h_r     <= in_tdata[93:71];
      flags_r <= in_tuser;
    end
  end

  // Shared multiplier: size times Q.16 ratio, rounded half up.
  logic                        mul_quad;
  logic [nsq_pkg::SIZE_W-1:0]  mul_a;
  logic [16:0]                 mul_k;
  logic [39:0]                 mul_full;
  logic [39:0]                 mul_rnd;
  logic [nsq_pkg::PROD_W-1:0]  prod_r [4];

  assign mul_quad = (mode_r == nsq_pkg::MODE_QUAD);

  always_comb begin
    mul_a = border_r;
    mul_k = {1'b0, edge_rat_r[15:0]};
    case (cmd.mul_sel)
      2'd0: begin
        mul_a = mul_quad ? w_r : border_r;
        mul_k = mul_quad ? fit_r[16:0] : {1'b0, edge_rat_r[15:0]};
      end
      2'd1: begin
        mul_a = mul_quad ? h_r : border_r;
        mul_k = mul_quad ? fit_r[33:17] : {1'b0, edge_rat_r[31:16]};
      end
      2'd2: mul_k = {1'b0, edge_rat_r[47:32]};
      default: mul_k = {1'b0, edge_rat_r[63:48]};
    endcase
  end

  assign mul_full = {17'd0, mul_a} * {23'd0, mul_k};
  assign mul_rnd  = mul_full + 40'h8000;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r[cmd.mul_sel] <= mul_rnd[39:16];
    end
  end

  // Edge computation. In regular mode edges 0 and 1 hold the single quad.
  logic signed [nsq_pkg::EDGE_W-1:0] cx_e, cy_e;
  logic signed [nsq_pkg::EDGE_W-1:0] rx0, rx1, ry0, ry1;
  logic signed [nsq_pkg::EDGE_W-1:0] nx0, nx1, nx2, nx3, ny0, ny1, ny2, ny3;
  logic signed [nsq_pkg::UVSUM_W-1:0] u0_e, v0_e, uend, vend;
  logic signed [nsq_pkg::UVSUM_W-1:0] nu1, nu2, nv1, nv2;
  logic [nsq_pkg::POS_W-1:0] xe_r [4];
  logic [nsq_pkg::POS_W-1:0] ye_r [4];
  logic [nsq_pkg::UV_W-1:0]  ue_r [4];
  logic [nsq_pkg::UV_W-1:0]  ve_r [4];

  always_comb begin
    cx_e = nsq_pkg::EDGE_W'($signed(cx_r));
    cy_e = nsq_pkg::EDGE_W'($signed(cy_r));
    rx0  = cx_e - $signed({3'd0, prod_r[0][23:1]});
    rx1  = rx0 + $signed({2'd0, prod_r[0]});
    ry0  = cy_e - $signed({3'd0, prod_r[1][23:1]});
    ry1  = ry0 + $signed({2'd0, prod_r[1]});
    nx0  = cx_e - $signed({4'd0, w_r[22:1]});
    nx3  = nx0 + $signed({3'd0, w_r});
    nx1  = nx0 + $signed({2'd0, prod_r[0]});
    nx2  = nx3 - $signed({2'd0, prod_r[1]});
    ny0  = cy_e - $signed({4'd0, h_r[22:1]});
    ny3  = ny0 + $signed({3'd0, h_r});
    ny1  = ny0 + $signed({2'd0, prod_r[2]});
    ny2  = ny3 - $signed({2'd0, prod_r[3]});
    u0_e = $signed({3'd0, uv_rect_r[15:0]});
    v0_e = $signed({3'd0, uv_rect_r[31:16]});
    uend = u0_e + $signed({3'd0, uv_rect_r[47:32]});
    vend = v0_e + $signed({3'd0, uv_rect_r[63:48]});
    nu1  = u0_e + $signed({3'd0, uv_marg_r[15:0]});
    nu2  = uend - $signed({3'd0, uv_marg_r[31:16]});
    nv1  = v0_e + $signed({3'd0, uv_marg_r[47:32]});
    nv2  = vend - $signed({3'd0, uv_marg_r[63:48]});
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_en) begin
      xe_r[0] <= nsq_pkg::sat_pos(mul_quad ? rx0 : nx0);
      xe_r[1] <= nsq_pkg::sat_pos(mul_quad ? rx1 : nx1);
      xe_r[2] <= nsq_pkg::sat_pos(nx2);
      xe_r[3] <= nsq_pkg::sat_pos(nx3);
      ye_r[0] <= nsq_pkg::sat_pos(mul_quad ? ry0 : ny0);
      ye_r[1] <= nsq_pkg::sat_pos(mul_quad ? ry1 : ny1);
      ye_r[2] <= nsq_pkg::sat_pos(ny2);
      ye_r[3] <= nsq_pkg::sat_pos(ny3);
      ue_r[0] <= nsq_pkg::sat_uv(u0_e);
      ue_r[1] <= nsq_pkg::sat_uv(mul_quad ? uend : nu1);
      ue_r[2] <= nsq_pkg::sat_uv(nu2);
      ue_r[3] <= nsq_pkg::sat_uv(uend);
      ve_r[0] <= nsq_pkg::sat_uv(v0_e);
      ve_r[1] <= nsq_pkg::sat_uv(mul_quad ? vend : nv1);
      ve_r[2] <= nsq_pkg::sat_uv(nv2);
      ve_r[3] <= nsq_pkg::sat_uv(vend);
    end
  end

  // Store writes.
  logic [3:0] sel;
  logic [1:0] xi, yi;
  logic pos_upd, uv_upd;
  logic pos_we, uv_we, col_we;
  logic [POS2-1:0]  pos_wdata, pos_q;
  logic [UVT_W-1:0] uv_wdata, uv_q;
  logic [nsq_pkg::COLOR_W-1:0] col_q;
  logic [AW-1:0] addr;

  assign sel = nsq_pkg::corner_edges(cmd.addr);
  assign xi  = sel[3:2];
  assign yi  = sel[1:0];
  assign addr = cmd.addr[AW-1:0];

  assign pos_upd = mul_quad ? (flags_r[nsq_pkg::FLAG_TRANSFORM] | flags_r[nsq_pkg::FLAG_SPRITE])
                            : (flags_r[nsq_pkg::FLAG_TRANSFORM] | flags_r[nsq_pkg::FLAG_BORDER]);
  assign uv_upd  = mul_quad ? (flags_r[nsq_pkg::FLAG_TRANSFORM] | flags_r[nsq_pkg::FLAG_SPRITE])
                            : flags_r[nsq_pkg::FLAG_SPRITE];
  assign pos_we  = cmd.wr_en & pos_upd;
  assign uv_we   = cmd.wr_en & uv_upd;
  assign col_we  = cmd.wr_en & flags_r[nsq_pkg::FLAG_COLOR];

  assign pos_wdata = {ye_r[yi], xe_r[xi]};
  assign uv_wdata  = {tex_slot_r, ve_r[yi], ue_r[xi]};

  nsq_ram #(.WIDTH(POS2), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (addr),
    .wdata (pos_wdata),
    .re    (cmd.rd_en),
    .raddr (addr),
    .rdata (pos_q)
  );

  nsq_ram #(.WIDTH(UVT_W), .DEPTH(MAX_VERTICES)) u_uv_ram (
    .clk   (clk),
    .we    (uv_we),
    .waddr (addr),
    .wdata (uv_wdata),
    .re    (cmd.rd_en),
    .raddr (addr),
    .rdata (uv_q)
  );

  nsq_ram #(.WIDTH(nsq_pkg::COLOR_W), .DEPTH(MAX_VERTICES)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (addr),
    .wdata (fill_r),
    .re    (cmd.rd_en),
    .raddr (addr),
    .rdata (col_q)
  );

  // An entry never written reads as zero, matching the cleared store.
  logic [MAX_VERTICES-1:0] pos_vld_r, uv_vld_r, col_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_vld_r <= '0;
      uv_vld_r  <= '0;
      col_vld_r <= '0;
    end else begin
      if (pos_we) pos_vld_r[addr] <= 1'b1;
      if (uv_we)  uv_vld_r[addr]  <= 1'b1;
      if (col_we) col_vld_r[addr] <= 1'b1;
    end
  end

  // Emission: one pending read slot in front of the output register.
  logic pend_r, pend_last_r;
  logic [nsq_pkg::VTX_W-1:0] pend_num_r;
  logic pos_vq_r, uv_vq_r, col_vq_r;
  logic out_valid_r, out_last_r;
  logic [nsq_pkg::OUT_DATA_W-1:0] out_data_r;
  logic load;
  logic [POS2-1:0]  pos_d;
  logic [UVT_W-1:0] uv_d;
  logic [nsq_pkg::COLOR_W-1:0] col_d;

  assign load  = pend_r & (!out_valid_r | out_tready);
  assign pos_d = pos_vq_r ? pos_q : '0;
  assign uv_d  = uv_vq_r ? uv_q : '0;
  assign col_d = col_vq_r ? col_q : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= cmd.rd_en | (pend_r & !load);
      out_valid_r <= load | (out_valid_r & !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      pend_num_r  <= cmd.addr;
      pend_last_r <= cmd.rd_last;
      pos_vq_r    <= pos_vld_r[addr];
      uv_vq_r     <= uv_vld_r[addr];
      col_vq_r    <= col_vld_r[addr];
    end
    if (load) begin
      out_data_r <= {2'd0, pend_num_r, col_d, uv_d, pos_d};
      out_last_r <= pend_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign sts.mode     = mode_r;
  assign sts.rd_free  = !pend_r | load;
  assign sts.run_done = out_valid_r & out_tready & out_last_r;

endmodule

// File: hw/rtl/nine_slice_quad_generator.sv
// Top level of the nine-slice quad generator: ties the controller and the datapath.
// Depends on nsq_pkg, nsq_ctrl, nsq_datapath and nsq_ram.
//
// Use: a request item on the in_ channel carries a rectangle center and size
// in tdata and four update flags in tuser. The block rewrites the selected
// parts of its vertex stores and then emits the stored vertices on the out_
// channel, one item per vertex, tlast on the final one. Regular mode emits
// 4 vertices, nine-sliced mode emits MAX_VERTICES; disabled mode emits none.
// Configuration registers must be written on the cfg_ port only while the block is
// idle; the block itself does not enforce this. Each item passes through the
// multiply phase (four products on one shared 23x17 multiplier), the edge phase,
// the store writes for its n vertices and then the output of those n vertices,
// with n = 4 or MAX_VERTICES. One item is in work at a time and in_tready is
// high only between runs. A stalled receiver holds the output register; the store
// read in flight waits in one slot behind it, so no vertex is lost or repeated.
// Reset (synchronous, active low) clears the configuration to zero and marks
// every store entry as zero through per-entry valid bits; no clearing pass.
`timescale 1ns / 1ps

module nine_slice_quad_generator #(
  parameter int MAX_VERTICES = 36
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [nsq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nsq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // center_x[23:0], center_y[47:24], rect_width[70:48], rect_height[93:71], zero pad
  input  logic [nsq_pkg::IN_DATA_W-1:0]     in_tdata,
  // upd_transform[0], upd_sprite[1], upd_border[2], upd_color[3]
  input  logic [nsq_pkg::FLAG_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // vertex_x[23:0], vertex_y[47:24], tex_u[63:48], tex_v[79:64],
  // vertex_texture[95:80], vertex_color[127:96], vertex_number[133:128], zero pad
  output logic [nsq_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast
);

  nsq_pkg::nsq_cmd_t cmd;
  nsq_pkg::nsq_sts_t sts;

  nsq_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nsq_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: hw/rtl/nsq_checker.sv
// Port-level checker of the nine-slice quad generator, bound to the top level.
// Depends on nsq_pkg.
`timescale 1ns / 1ps

module nsq_checker #(
  parameter int MAX_VERTICES = 36
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [nsq_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast
);

  localparam logic [nsq_pkg::VTX_W-1:0] NINE_LAST = nsq_pkg::VTX_W'(MAX_VERTICES - 1);

  logic [nsq_pkg::VTX_W-1:0] vnum;
  assign vnum = out_tdata[nsq_pkg::OUT_NUM_LSB +: nsq_pkg::VTX_W];

  // A stalled item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  // A new request is only taken once the previous run has drained.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while a vertex is pending");

  // The last vertex taken returns the block to accepting requests.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("block not ready after the end of a run");

  // A run starts at vertex zero.
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> vnum == '0)
    else $error("run did not start at vertex zero");

  // A run ends after a whole quad or the whole store.
  a_last_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> vnum == nsq_pkg::QUAD_LAST || vnum == NINE_LAST)
    else $error("run ended at an unexpected vertex");

endmodule

bind nine_slice_quad_generator nsq_checker #(.MAX_VERTICES(MAX_VERTICES)) u_nsq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
